@@ design/rmeu_pkg.sv @@
// shared constants, opcodes and controller/datapath command types
`default_nettype none
package rmeu_pkg;
  localparam int unsigned PARAM_REGS   = 8;
  localparam int unsigned GENERAL_REGS = 32;
  localparam int unsigned DATA_W       = 64;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned MODE_W       = 4;
  localparam logic [IDX_W-1:0] PMASK   = 5'd7;
  localparam logic [IDX_W-1:0] GMASK   = 5'd31;

  localparam logic [MODE_W-1:0] OP_MOVCONST = 4'd0;
  localparam logic [MODE_W-1:0] OP_MOVE     = 4'd1;
  localparam logic [MODE_W-1:0] OP_ADD      = 4'd2;
  localparam logic [MODE_W-1:0] OP_SUB      = 4'd3;
  localparam logic [MODE_W-1:0] OP_MUL      = 4'd4;
  localparam logic [MODE_W-1:0] OP_DIV      = 4'd5;
  localparam logic [MODE_W-1:0] OP_AND      = 4'd6;
  localparam logic [MODE_W-1:0] OP_OR       = 4'd7;
  localparam logic [MODE_W-1:0] OP_XOR      = 4'd8;
  localparam logic [MODE_W-1:0] OP_RETVAL   = 4'd9;
  localparam logic [MODE_W-1:0] OP_RETVOID  = 4'd10;

  localparam logic [1:0] KIND_CONST = 2'd1;
  localparam logic [1:0] KIND_REG   = 2'd2;

  typedef struct packed {
    logic load;      // capture transaction, read operands
    logic start_mul;
    logic start_div;
    logic commit;    // write back and build result
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic finished;
  } sts_t;
endpackage
`default_nettype wire

@@ design/rmeu_mul.sv @@
// iterative 64x64 multiplier, low product, 16 bits of operand per cycle
`default_nettype none
module rmeu_mul (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [rmeu_pkg::DATA_W-1:0]  a_i,
  input  wire logic [rmeu_pkg::DATA_W-1:0]  b_i,
  output logic                              done_o,
  output logic [rmeu_pkg::DATA_W-1:0]       p_o
);
  logic [rmeu_pkg::DATA_W-1:0] a_q, a_d, b_q, b_d, p_q, p_d;
  logic [2:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [rmeu_pkg::DATA_W+15:0] part;

  always_comb begin
    a_d = a_q; b_d = b_q; p_d = p_q; cnt_d = cnt_q; busy_d = busy_q;
    part = a_q * {{(rmeu_pkg::DATA_W){1'b0}}, b_q[15:0]};
    done_o = 1'b0;
    if (start_i) begin
      a_d = a_i; b_d = b_i; p_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      p_d = p_q + part[rmeu_pkg::DATA_W-1:0];
      a_d = {a_q[rmeu_pkg::DATA_W-17:0], 16'd0};
      b_d = {16'd0, b_q[rmeu_pkg::DATA_W-1:16]};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd3) begin
        busy_d = 1'b0;
      end
    end
    if (!busy_q && cnt_q == 3'd4) begin
      done_o = 1'b1;
    end
  end

  assign p_o = p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= (start_i || busy_q) ? cnt_d : (done_o ? 3'd0 : cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end
endmodule
`default_nettype wire

@@ design/rmeu_div.sv @@
// radix-2 restoring signed divider, one quotient bit per cycle
`default_nettype none
module rmeu_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [rmeu_pkg::DATA_W-1:0]  a_i,
  input  wire logic [rmeu_pkg::DATA_W-1:0]  b_i,
  output logic                              done_o,
  output logic [rmeu_pkg::DATA_W-1:0]       q_o
);
  localparam int unsigned W = rmeu_pkg::DATA_W;
  logic [W-1:0] q_q, d_q, r_q;
  logic [W:0] trial;
  logic neg_q, zero_q, busy_q, fin_q;
  logic [6:0] cnt_q;

  assign trial = {r_q, q_q[W-1]} - {1'b0, d_q};
  assign done_o = fin_q;
  always_comb begin
    if (zero_q) begin
      q_o = '0;
    end else if (neg_q) begin
      q_o = '0 - q_q;
    end else begin
      q_o = q_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'(W - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q    <= a_i[W-1] ? ('0 - a_i) : a_i;
      d_q    <= b_i[W-1] ? ('0 - b_i) : b_i;
      r_q    <= '0;
      neg_q  <= a_i[W-1] ^ b_i[W-1];
      zero_q <= (b_i == '0);
    end else if (busy_q) begin
      if (!trial[W]) begin
        r_q <= trial[W-1:0];
        q_q <= {q_q[W-2:0], 1'b1};
      end else begin
        r_q <= {r_q[W-2:0], q_q[W-1]};
        q_q <= {q_q[W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ design/rmeu_datapath.sv @@
// register banks, operand fetch, alu and result register
`default_nettype none
module rmeu_datapath #(
  parameter int unsigned PARAM_REGS   = rmeu_pkg::PARAM_REGS,
  parameter int unsigned GENERAL_REGS = rmeu_pkg::GENERAL_REGS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rmeu_pkg::cmd_t                cmd_i,
  output rmeu_pkg::sts_t                     sts_o,
  input  wire logic [rmeu_pkg::MODE_W-1:0]   mode_i,
  input  wire logic                          dest_is_param_i,
  input  wire logic [rmeu_pkg::IDX_W-1:0]    dest_index_i,
  input  wire logic [1:0]                    src1_kind_i,
  input  wire logic                          src1_is_param_i,
  input  wire logic [rmeu_pkg::IDX_W-1:0]    src1_index_i,
  input  wire logic [rmeu_pkg::DATA_W-1:0]   src1_const_i,
  input  wire logic [1:0]                    src2_kind_i,
  input  wire logic                          src2_is_param_i,
  input  wire logic [rmeu_pkg::IDX_W-1:0]    src2_index_i,
  input  wire logic [rmeu_pkg::DATA_W-1:0]   src2_const_i,
  output logic                               wrote_o,
  output logic                               write_is_param_o,
  output logic [rmeu_pkg::IDX_W-1:0]         write_index_o,
  output logic [rmeu_pkg::DATA_W-1:0]        write_value_o,
  output logic                               finished_o,
  output logic                               ignored_o
);
  localparam int unsigned W = rmeu_pkg::DATA_W;

  logic [W-1:0] pbank_q [PARAM_REGS];
  logic [W-1:0] gbank_q [GENERAL_REGS];
  logic         done_q;

  logic [rmeu_pkg::MODE_W-1:0] mode_q;
  logic                        dpar_q;
  logic [rmeu_pkg::IDX_W-1:0]  didx_q;
  logic [W-1:0]                a_q, b_q, c_q;
  logic [W-1:0]                mul_p, div_q;
  logic                        mul_done, div_done;

  function automatic logic [W-1:0] rd(
    input logic [W-1:0] pb [PARAM_REGS], input logic [W-1:0] gb [GENERAL_REGS],
    input logic [1:0] kind, input logic is_p, input logic [rmeu_pkg::IDX_W-1:0] idx,
    input logic [W-1:0] cval);
    logic [rmeu_pkg::IDX_W-1:0] i;
    logic [W-1:0] v;
    v = '0;
    if (kind == rmeu_pkg::KIND_CONST) begin
      v = cval;
    end else if (kind == rmeu_pkg::KIND_REG) begin
      if (is_p) begin
        i = idx & rmeu_pkg::PMASK;
        for (int k = 0; k < PARAM_REGS; k++) if (32'(i) == k) v = pb[k];
      end else begin
        i = idx & rmeu_pkg::GMASK;
        for (int k = 0; k < GENERAL_REGS; k++) if (32'(i) == k) v = gb[k];
      end
    end
    return v;
  endfunction

  rmeu_mul u_mul (
    .clk_i, .rst_ni, .start_i(cmd_i.start_mul), .a_i(a_q), .b_i(b_q),
    .done_o(mul_done), .p_o(mul_p)
  );
  rmeu_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.start_div), .a_i(a_q), .b_i(b_q),
    .done_o(div_done), .q_o(div_q)
  );

  assign sts_o = '{mul_done: mul_done, div_done: div_done, finished: done_q};

  logic [W-1:0] val;
  logic         wr, wpar, ret, setdone;
  logic [rmeu_pkg::IDX_W-1:0] widx;
  always_comb begin
    val = '0; wr = 1'b0; ret = 1'b0; setdone = 1'b0;
    case (mode_q)
      rmeu_pkg::OP_MOVCONST: begin val = c_q; wr = 1'b1; end
      rmeu_pkg::OP_MOVE:     begin val = a_q; wr = 1'b1; end
      rmeu_pkg::OP_ADD:      begin val = a_q + b_q; wr = 1'b1; end
      rmeu_pkg::OP_SUB:      begin val = a_q - b_q; wr = 1'b1; end
      rmeu_pkg::OP_MUL:      begin val = mul_p; wr = 1'b1; end
      rmeu_pkg::OP_DIV:      begin val = div_q; wr = 1'b1; end
      rmeu_pkg::OP_AND:      begin val = a_q & b_q; wr = 1'b1; end
      rmeu_pkg::OP_OR:       begin val = a_q | b_q; wr = 1'b1; end
      rmeu_pkg::OP_XOR:      begin val = a_q ^ b_q; wr = 1'b1; end
      rmeu_pkg::OP_RETVAL:   begin val = a_q; ret = 1'b1; setdone = 1'b1; end
      rmeu_pkg::OP_RETVOID:  setdone = 1'b1;
      default: ;
    endcase
    wpar = dpar_q;
    widx = dpar_q ? (didx_q & rmeu_pkg::PMASK) : (didx_q & rmeu_pkg::GMASK);
    if (wr) begin
      if (dpar_q ? (32'(widx) >= PARAM_REGS) : (32'(widx) >= GENERAL_REGS)) wr = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      for (int k = 0; k < PARAM_REGS; k++) pbank_q[k] <= '0;
      for (int k = 0; k < GENERAL_REGS; k++) gbank_q[k] <= '0;
    end else if (cmd_i.commit && !done_q) begin
      if (setdone) done_q <= 1'b1;
      if (ret) gbank_q[0] <= val;
      if (wr && wpar) begin
        for (int k = 0; k < PARAM_REGS; k++) if (32'(widx) == k) pbank_q[k] <= val;
      end
      if (wr && !wpar) begin
        for (int k = 0; k < GENERAL_REGS; k++) if (32'(widx) == k) gbank_q[k] <= val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      dpar_q <= dest_is_param_i;
      didx_q <= dest_index_i;
      c_q    <= src1_const_i;
      a_q    <= rd(pbank_q, gbank_q, src1_kind_i, src1_is_param_i, src1_index_i, src1_const_i);
      b_q    <= rd(pbank_q, gbank_q, src2_kind_i, src2_is_param_i, src2_index_i, src2_const_i);
    end
    if (cmd_i.commit) begin
      if (done_q) begin
        wrote_o <= 1'b0; write_is_param_o <= 1'b0; write_index_o <= '0;
        write_value_o <= '0; finished_o <= 1'b1; ignored_o <= 1'b1;
      end else begin
        wrote_o          <= wr || ret;
        write_is_param_o <= wr && wpar;
        write_index_o    <= wr ? widx : '0;
        write_value_o    <= (wr || ret) ? val : '0;
        finished_o       <= setdone;
        ignored_o        <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ design/rmeu_ctrl.sv @@
// controller state machine: fetch, execute wait, result handshake
`default_nettype none
module rmeu_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  input  wire logic [rmeu_pkg::MODE_W-1:0]  mode_i,
  input  wire rmeu_pkg::sts_t               sts_i,
  output rmeu_pkg::cmd_t                    cmd_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic [rmeu_pkg::MODE_W-1:0] mode_q;
  logic ovalid_q, ovalid_d;
  logic in_acc, out_free;

  assign out_free    = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.load = in_acc;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_EXEC;
      S_EXEC: begin
        if (!sts_i.finished && mode_q == rmeu_pkg::OP_MUL) begin
          cmd_o.start_mul = 1'b1;
          state_d = S_WAIT;
        end else if (!sts_i.finished && mode_q == rmeu_pkg::OP_DIV) begin
          cmd_o.start_div = 1'b1;
          state_d = S_WAIT;
        end else if (out_free) begin
          cmd_o.commit = 1'b1;
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_WAIT: begin
        if ((sts_i.mul_done || sts_i.div_done) && out_free) begin
          cmd_o.commit = 1'b1;
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end else if (sts_i.mul_done || sts_i.div_done) begin
          state_d = S_EXEC;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      mode_q   <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (in_acc) mode_q <= mode_i;
      if (state_q == S_WAIT && (sts_i.mul_done || sts_i.div_done) && !out_free) begin
        mode_q <= rmeu_pkg::OP_MOVCONST;
      end
    end
  end
endmodule
`default_nettype wire

@@ design/register_machine_execute_unit_top.sv @@
// top level of the register machine execute unit
//
// channel  direction  handshake              payload
// in       input      in_valid_i/in_ready_o  mode_i .. src2_const_i
// out      output     out_valid_o/out_ready_i wrote_o .. ignored_o
//
// a transaction is fetched, then executed and committed at the result hand-off; mul and
// div first wait for the multiplier or the 64-step divider
// one transaction in flight; in_ready_o stays low until its result is registered
// a stalled output holds the result and the controller until it is taken
// reset clears both register banks and the finished flag at once
`default_nettype none
module register_machine_execute_unit_top #(
  parameter int unsigned PARAM_REGS   = rmeu_pkg::PARAM_REGS,
  parameter int unsigned GENERAL_REGS = rmeu_pkg::GENERAL_REGS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [rmeu_pkg::MODE_W-1:0]   mode_i,
  input  wire logic                          dest_is_param_i,
  input  wire logic [rmeu_pkg::IDX_W-1:0]    dest_index_i,
  input  wire logic [1:0]                    src1_kind_i,
  input  wire logic                          src1_is_param_i,
  input  wire logic [rmeu_pkg::IDX_W-1:0]    src1_index_i,
  input  wire logic [rmeu_pkg::DATA_W-1:0]   src1_const_i,
  input  wire logic [1:0]                    src2_kind_i,
  input  wire logic                          src2_is_param_i,
  input  wire logic [rmeu_pkg::IDX_W-1:0]    src2_index_i,
  input  wire logic [rmeu_pkg::DATA_W-1:0]   src2_const_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               wrote_o,
  output logic                               write_is_param_o,
  output logic [rmeu_pkg::IDX_W-1:0]         write_index_o,
  output logic [rmeu_pkg::DATA_W-1:0]        write_value_o,
  output logic                               finished_o,
  output logic                               ignored_o
);
  rmeu_pkg::cmd_t cmd;
  rmeu_pkg::sts_t sts;

  rmeu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .mode_i, .sts_i(sts), .cmd_o(cmd)
  );

  rmeu_datapath #(.PARAM_REGS(PARAM_REGS), .GENERAL_REGS(GENERAL_REGS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .mode_i, .dest_is_param_i, .dest_index_i,
    .src1_kind_i, .src1_is_param_i, .src1_index_i, .src1_const_i,
    .src2_kind_i, .src2_is_param_i, .src2_index_i, .src2_const_i,
    .wrote_o, .write_is_param_o, .write_index_o, .write_value_o,
    .finished_o, .ignored_o
  );
endmodule
`default_nettype wire
